// ===== sv/srp_pkg.sv =====
// srp_pkg: shared types, codes and constants of the servo reply packet parser
// used by every module of the parser and by its checker; no dependencies
`default_nettype none

package srp_pkg;

  localparam int unsigned SYNC_LIMIT_DEF = 32;
  localparam int unsigned MAX_BODY_DEF   = 32;
  localparam int unsigned STORE_DEPTH    = 30;
  localparam int unsigned IDX_W          = 5;
  localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
  localparam logic [7:0]  MIN_LEN        = 8'd2;
  localparam logic [IDX_W-1:0] MAX_PARAMS_RST = IDX_W'(STORE_DEPTH);

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_BYTE    = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_PARAM  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_FAIL   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    FAIL_NO_HEADER = 3'd0,
    FAIL_TIMEOUT   = 3'd1,
    FAIL_LEN_SHORT = 3'd2,
    FAIL_LEN_LONG  = 3'd3,
    FAIL_CHECKSUM  = 3'd4
  } fail_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       param_byte;
    logic [IDX_W-1:0] param_index;
    logic [IDX_W-1:0] param_count;
    logic [7:0]       servo_error;
    logic [7:0]       responder_id;
    logic [2:0]       fail_reason;
    logic             last;
  } out_rsp_t;

  typedef struct packed {
    logic  clear;
    logic  hunt_step;
    logic  take_id;
    logic  take_len;
    logic  body_step;
    logic  begin_drain;
    logic  param_next;
    logic  emit;
    kind_t emit_kind;
    fail_t fail_reason;
  } ctl_cmd_t;

  typedef struct packed {
    logic synced;
    logic hunt_limit;
    logic len_short;
    logic len_long;
    logic body_last;
    logic csum_ok;
    logic cnt_zero;
    logic drain_last;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== sv/srp_ctrl.sv =====
// srp_ctrl: reception state machine of the servo reply packet parser
// drives datapath commands from srp_pkg types; depends on srp_pkg
`default_nettype none

module srp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_op,
  output logic                   in_stall,
  input  wire srp_pkg::ctl_sts_t st,
  output srp_pkg::ctl_cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_HUNT = 8'b0000_0010,
    S_ID   = 8'b0000_0100,
    S_LEN  = 8'b0000_1000,
    S_BODY = 8'b0001_0000,
    S_RD   = 8'b0010_0000,
    S_EMIT = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   draining;
  logic   accept;

  assign draining = (state_r == S_RD) || (state_r == S_EMIT) || (state_r == S_DONE);
  assign in_stall = draining || !st.out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.emit_kind   = srp_pkg::KIND_FAIL;
    cmd.fail_reason = srp_pkg::FAIL_NO_HEADER;
    unique case (state_r)
      S_IDLE, S_HUNT, S_ID, S_LEN, S_BODY: begin
        if (accept) begin
          unique case (in_op)
            srp_pkg::OP_START: begin
              cmd.clear = 1'b1;
              state_nxt = S_HUNT;
            end
            srp_pkg::OP_TIMEOUT: begin
              if (state_r != S_IDLE) begin
                cmd.emit        = 1'b1;
                cmd.fail_reason = srp_pkg::FAIL_TIMEOUT;
                state_nxt       = S_IDLE;
              end
            end
            srp_pkg::OP_BYTE: begin
              unique case (state_r)
                S_HUNT: begin
                  cmd.hunt_step = 1'b1;
                  if (st.synced) begin
                    state_nxt = S_ID;
                  end else if (st.hunt_limit) begin
                    cmd.emit        = 1'b1;
                    cmd.fail_reason = srp_pkg::FAIL_NO_HEADER;
                    state_nxt       = S_IDLE;
                  end
                end
                S_ID: begin
                  cmd.take_id = 1'b1;
                  state_nxt   = S_LEN;
                end
                S_LEN: begin
                  if (st.len_short) begin
                    cmd.emit        = 1'b1;
                    cmd.fail_reason = srp_pkg::FAIL_LEN_SHORT;
                    state_nxt       = S_IDLE;
                  end else if (st.len_long) begin
                    cmd.emit        = 1'b1;
                    cmd.fail_reason = srp_pkg::FAIL_LEN_LONG;
                    state_nxt       = S_IDLE;
                  end else begin
                    cmd.take_len = 1'b1;
                    state_nxt    = S_BODY;
                  end
                end
                S_BODY: begin
                  if (!st.body_last) begin
                    cmd.body_step = 1'b1;
                  end else if (!st.csum_ok) begin
                    cmd.emit        = 1'b1;
                    cmd.fail_reason = srp_pkg::FAIL_CHECKSUM;
                    state_nxt       = S_IDLE;
                  end else begin
                    cmd.begin_drain = 1'b1;
                    state_nxt       = st.cnt_zero ? S_DONE : S_RD;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = srp_pkg::KIND_PARAM;
          cmd.param_next = 1'b1;
          state_nxt      = st.drain_last ? S_DONE : S_RD;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = srp_pkg::KIND_ACCEPT;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srp_datapath.sv =====
// srp_datapath: header registers, checksum, parameter buffer and result register
// executes srp_ctrl commands and reports status; depends on srp_pkg
`default_nettype none

module srp_datapath #(
  parameter int unsigned SYNC_LIMIT = srp_pkg::SYNC_LIMIT_DEF,
  parameter int unsigned MAX_BODY   = srp_pkg::MAX_BODY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire srp_pkg::in_req_t            in_req,
  input  wire logic                        cfg_wr_en,
  input  wire logic [srp_pkg::IDX_W-1:0]   cfg_wr_data,
  input  wire srp_pkg::ctl_cmd_t           cmd,
  output srp_pkg::ctl_sts_t                st,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output srp_pkg::out_rsp_t                out_rsp
);

  localparam int unsigned IW    = srp_pkg::IDX_W;
  localparam int unsigned LEN_W = $clog2(MAX_BODY + 1);
  localparam int unsigned SC_W  = $clog2(SYNC_LIMIT + 1);
  localparam int unsigned PW    = (LEN_W > IW) ? LEN_W : IW;

  logic [7:0]       b;
  logic [7:0]       prev_r;
  logic [SC_W-1:0]  sc_r;
  logic [7:0]       id_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] pos_r;
  logic [7:0]       sum_r;
  logic [7:0]       err_r;
  logic [IW-1:0]    cnt_r;
  logic [IW-1:0]    idx_r;
  logic [IW-1:0]    maxp_r;
  logic [7:0]       rd_data_r;
  logic [7:0]       mem [0:srp_pkg::STORE_DEPTH-1];

  logic             out_valid_r;
  srp_pkg::out_rsp_t out_rsp_r, rsp_nxt;

  logic [LEN_W-1:0] nparams;
  logic [IW-1:0]    cnt_calc;
  logic [PW-1:0]    pos_ext;
  logic [PW-1:0]    pidx;
  logic             wr_ok;

  assign b = in_req.data_byte;

  assign nparams  = len_r - LEN_W'(2);
  assign cnt_calc = (PW'(nparams) < PW'(maxp_r)) ? IW'(nparams) : maxp_r;
  assign pos_ext  = PW'(pos_r);
  assign pidx     = pos_ext - PW'(1);
  assign wr_ok    = (pos_r != '0) && (pidx < PW'(srp_pkg::STORE_DEPTH));

  always_comb begin
    st            = '0;
    st.synced     = (prev_r == srp_pkg::SYNC_BYTE) && (b == srp_pkg::SYNC_BYTE);
    st.hunt_limit = ((SC_W+1)'(sc_r) + (SC_W+1)'(1)) >= (SC_W+1)'(SYNC_LIMIT);
    st.len_short  = b < srp_pkg::MIN_LEN;
    st.len_long   = b > 8'(MAX_BODY);
    st.body_last  = pos_r == (len_r - LEN_W'(1));
    st.csum_ok    = (~sum_r) == b;
    st.cnt_zero   = cnt_calc == '0;
    st.drain_last = (idx_r + IW'(1)) == cnt_r;
    st.out_free   = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      prev_r <= '0;
      sc_r   <= '0;
      id_r   <= '0;
      len_r  <= '0;
      pos_r  <= '0;
      sum_r  <= '0;
      err_r  <= '0;
    end
    if (cmd.hunt_step) begin
      prev_r <= b;
      sc_r   <= sc_r + SC_W'(1);
    end
    if (cmd.take_id) begin
      id_r <= b;
    end
    if (cmd.take_len) begin
      len_r <= LEN_W'(b);
      pos_r <= '0;
      sum_r <= id_r + b;
    end
    if (cmd.body_step) begin
      if (pos_r == '0) begin
        err_r <= b;
      end
      sum_r <= sum_r + b;
      pos_r <= pos_r + LEN_W'(1);
    end
    if (cmd.begin_drain) begin
      cnt_r <= cnt_calc;
      idx_r <= '0;
    end
    if (cmd.param_next) begin
      idx_r <= idx_r + IW'(1);
    end
  end

  // parameter buffer, single write port and registered read
  always_ff @(posedge clk) begin
    if (cmd.body_step && wr_ok) begin
      mem[IW'(pidx)] <= b;
    end
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxp_r <= srp_pkg::MAX_PARAMS_RST;
    end else if (cfg_wr_en) begin
      maxp_r <= (cfg_wr_data > srp_pkg::MAX_PARAMS_RST) ? srp_pkg::MAX_PARAMS_RST
                                                         : cfg_wr_data;
    end
  end

  always_comb begin
    rsp_nxt              = '0;
    rsp_nxt.kind         = cmd.emit_kind;
    rsp_nxt.responder_id = id_r;
    case (cmd.emit_kind)
      srp_pkg::KIND_PARAM: begin
        rsp_nxt.param_byte  = rd_data_r;
        rsp_nxt.param_index = idx_r;
        rsp_nxt.param_count = cnt_r;
      end
      srp_pkg::KIND_ACCEPT: begin
        rsp_nxt.param_count = cnt_r;
        rsp_nxt.servo_error = err_r;
        rsp_nxt.last        = 1'b1;
      end
      default: begin
        rsp_nxt.fail_reason = cmd.fail_reason;
        rsp_nxt.last        = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

`default_nettype wire

// ===== sv/servo_reply_packet_parser_core.sv =====
// results: a failure result is on out the cycle after its request; after a good
// checksum each parameter passes S_RD and S_EMIT, and the done result S_DONE
// throughput: one request per cycle while receiving and out is free; after a good
// checksum, requests stall while the parameters and the done result are emitted
// reset: synchronous active-low, clears the state machine and result valid flag,
// sets max_params to 30; the parameter buffer is not cleared
`default_nettype none

module servo_reply_packet_parser_core #(
  parameter int unsigned SYNC_LIMIT = srp_pkg::SYNC_LIMIT_DEF,
  parameter int unsigned MAX_BODY   = srp_pkg::MAX_BODY_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire srp_pkg::in_req_t          in_req,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output srp_pkg::out_rsp_t              out_rsp,
  input  wire logic                      cfg_wr_en,
  input  wire logic [srp_pkg::IDX_W-1:0] cfg_wr_data
);

  srp_pkg::ctl_cmd_t cmd;
  srp_pkg::ctl_sts_t st;

  srp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_req.operation),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  srp_datapath #(
    .SYNC_LIMIT (SYNC_LIMIT),
    .MAX_BODY   (MAX_BODY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .st          (st),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_rsp     (out_rsp)
  );

endmodule

`default_nettype wire

// ===== sv/srp_checker.sv =====
// srp_checker: port-level assertions for the servo reply packet parser
// bound to servo_reply_packet_parser_core; depends on srp_pkg
`default_nettype none

module srp_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire srp_pkg::in_req_t          in_req,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire srp_pkg::out_rsp_t         out_rsp
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  a_param_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.kind == srp_pkg::KIND_PARAM |->
      !out_rsp.last && out_rsp.param_index < out_rsp.param_count)
    else $error("bad parameter result");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.kind == srp_pkg::KIND_ACCEPT || out_rsp.kind == srp_pkg::KIND_FAIL)
      |-> out_rsp.last)
    else $error("final result without last");

  a_drain_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.kind == srp_pkg::KIND_PARAM |-> in_stall)
    else $error("request taken during parameter drain");

  a_in_unused: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_req.operation == srp_pkg::OP_START |=> !out_valid ||
      $past(out_valid && out_stall))
    else $error("start produced a result");

endmodule

bind servo_reply_packet_parser_core srp_checker u_srp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for servo_reply_packet_parser_core, with a reply
// tracker that predicts results and checks them in order under random idling
// depends on srp_pkg and servo_reply_packet_parser_core
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] OP_RESERVED  = 2'd3;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned PHASE_ITEMS  = 40;

  typedef enum {PH_IDLE, PH_HUNT, PH_ID, PH_LEN, PH_BODY} parse_phase_t;
  typedef enum {
    SHAPE_GOOD, SHAPE_BAD_SUM, SHAPE_SHORT, SHAPE_LONG, SHAPE_TIMEOUT,
    SHAPE_NO_HEADER, SHAPE_RESTART
  } reply_shape_t;

  class reply_tracker;
    srp_pkg::out_rsp_t          expected_q[$];
    int unsigned                errors;
    logic [srp_pkg::IDX_W-1:0]  max_params;
    parse_phase_t               phase;
    logic [7:0]                 prev_byte;
    logic [7:0]                 resp_id;
    logic [7:0]                 err_byte;
    logic [7:0]                 sum;
    int unsigned                hunt_count;
    int unsigned                reply_len;
    int unsigned                body_pos;
    logic [7:0]                 store [srp_pkg::STORE_DEPTH];

    function new();
      errors = 0;
      max_params = srp_pkg::MAX_PARAMS_RST;
      phase = PH_IDLE;
      prev_byte = '0;
      resp_id = '0;
      err_byte = '0;
      sum = '0;
      hunt_count = 0;
      reply_len = 0;
      body_pos = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_max_params(logic [srp_pkg::IDX_W-1:0] v);
      max_params = (v > srp_pkg::STORE_DEPTH) ? srp_pkg::MAX_PARAMS_RST : v;
    endfunction

    local function void push(srp_pkg::kind_t kind, logic [7:0] pbyte, int unsigned pidx,
                             int unsigned pcount, logic [7:0] serr,
                             srp_pkg::fail_t reason, logic last);
      srp_pkg::out_rsp_t r;
      r.kind         = kind;
      r.param_byte   = pbyte;
      r.param_index  = srp_pkg::IDX_W'(pidx);
      r.param_count  = srp_pkg::IDX_W'(pcount);
      r.servo_error  = serr;
      r.responder_id = resp_id;
      r.fail_reason  = reason;
      r.last         = last;
      expected_q.push_back(r);
    endfunction

    local function void fail(srp_pkg::fail_t reason);
      push(srp_pkg::KIND_FAIL, 8'h00, 0, 0, 8'h00, reason, 1'b1);
      phase = PH_IDLE;
    endfunction

    // returns 1 when the request is acted on rather than ignored
    function bit take_request(srp_pkg::in_req_t r);
      logic [7:0]  b;
      int unsigned count;
      b = r.data_byte;
      if (r.operation == srp_pkg::OP_START) begin
        phase = PH_HUNT;
        prev_byte = '0;
        hunt_count = 0;
        resp_id = '0;
        reply_len = 0;
        body_pos = 0;
        sum = '0;
        err_byte = '0;
        return 1'b1;
      end
      if (r.operation == OP_RESERVED || phase == PH_IDLE) return 1'b0;
      if (r.operation == srp_pkg::OP_TIMEOUT) begin
        fail(srp_pkg::FAIL_TIMEOUT);
        return 1'b1;
      end
      case (phase)
        PH_HUNT: begin
          hunt_count++;
          if (prev_byte == srp_pkg::SYNC_BYTE && b == srp_pkg::SYNC_BYTE) begin
            phase = PH_ID;
          end else if (hunt_count >= srp_pkg::SYNC_LIMIT_DEF) begin
            fail(srp_pkg::FAIL_NO_HEADER);
          end
          prev_byte = b;
        end
        PH_ID: begin
          resp_id = b;
          phase = PH_LEN;
        end
        PH_LEN: begin
          if (b < srp_pkg::MIN_LEN) begin
            fail(srp_pkg::FAIL_LEN_SHORT);
          end else if (b > srp_pkg::MAX_BODY_DEF) begin
            fail(srp_pkg::FAIL_LEN_LONG);
          end else begin
            reply_len = 32'(b);
            body_pos = 0;
            sum = resp_id + b;
            phase = PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_pos + 1 < reply_len) begin
            if (body_pos == 0) err_byte = b;
            else if (body_pos - 1 < srp_pkg::STORE_DEPTH) store[body_pos - 1] = b;
            sum = sum + b;
            body_pos++;
          end else if (~sum != b) begin
            fail(srp_pkg::FAIL_CHECKSUM);
          end else begin
            count = reply_len - 2;
            if (count > max_params) count = 32'(max_params);
            if (count > srp_pkg::STORE_DEPTH) count = srp_pkg::STORE_DEPTH;
            for (int i = 0; i < count; i++)
              push(srp_pkg::KIND_PARAM, store[i], i, count, 8'h00,
                   srp_pkg::FAIL_NO_HEADER, 1'b0);
            push(srp_pkg::KIND_ACCEPT, 8'h00, 0, count, err_byte,
                 srp_pkg::FAIL_NO_HEADER, 1'b1);
            phase = PH_IDLE;
          end
        end
        default: phase = PH_IDLE;
      endcase
      return 1'b1;
    endfunction

    local function void match(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(srp_pkg::out_rsp_t got);
      srp_pkg::out_rsp_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      match("kind", 32'(want.kind), 32'(got.kind));
      match("param_byte", 32'(want.param_byte), 32'(got.param_byte));
      match("param_index", 32'(want.param_index), 32'(got.param_index));
      match("param_count", 32'(want.param_count), 32'(got.param_count));
      match("servo_error", 32'(want.servo_error), 32'(got.servo_error));
      match("responder_id", 32'(want.responder_id), 32'(got.responder_id));
      match("fail_reason", 32'(want.fail_reason), 32'(got.fail_reason));
      match("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  srp_pkg::in_req_t           in_req = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  srp_pkg::out_rsp_t          out_rsp;
  logic                       cfg_wr_en = 1'b0;
  logic [srp_pkg::IDX_W-1:0]  cfg_wr_data = '0;

  reply_tracker tracker = new();
  int unsigned  items_taken = 0;
  int unsigned  idle_cycles = 0;
  bit           no_idle = 1'b0;
  bit           hold_off = 1'b0;

  servo_reply_packet_parser_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_rsp     (out_rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_rsp);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver side: random stall stretches plus one long hold-off on request
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [7:0] b);
    srp_pkg::in_req_t r;
    int unsigned      gap;
    r.operation = op;
    r.data_byte = b;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (tracker.take_request(r)) items_taken++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_max_params(input logic [srp_pkg::IDX_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_max_params(v);
  endtask

  task automatic send_reply(input reply_shape_t shape, input int unsigned n_params);
    logic [7:0]  id;
    logic [7:0]  err;
    logic [7:0]  len;
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned noise;
    int          cut;
    id = 8'($urandom);
    err = 8'($urandom);
    noise = ($urandom_range(0, 3) == 0) ?
            $urandom_range(1, srp_pkg::SYNC_LIMIT_DEF - 2) : 0;
    send_op(srp_pkg::OP_START, 8'($urandom));
    if (shape == SHAPE_RESTART) begin
      repeat ($urandom_range(1, 6)) send_op(srp_pkg::OP_BYTE, 8'($urandom));
      send_op(srp_pkg::OP_START, 8'($urandom));
    end
    if (shape == SHAPE_NO_HEADER) begin
      repeat (srp_pkg::SYNC_LIMIT_DEF)
        send_op(srp_pkg::OP_BYTE, 8'($urandom_range(0, 254)));
      return;
    end
    repeat (noise) send_op(srp_pkg::OP_BYTE, 8'($urandom_range(0, 254)));
    send_op(srp_pkg::OP_BYTE, srp_pkg::SYNC_BYTE);
    send_op(srp_pkg::OP_BYTE, srp_pkg::SYNC_BYTE);
    send_op(srp_pkg::OP_BYTE, id);
    case (shape)
      SHAPE_SHORT: len = 8'($urandom_range(0, 1));
      SHAPE_LONG:  len = 8'($urandom_range(srp_pkg::MAX_BODY_DEF + 1, 255));
      default:     len = 8'(n_params + 2);
    endcase
    send_op(srp_pkg::OP_BYTE, len);
    if (shape == SHAPE_SHORT || shape == SHAPE_LONG) return;
    cut = (shape == SHAPE_TIMEOUT) ? $urandom_range(0, n_params + 1) : -1;
    sum = id + len;
    for (int i = 0; i <= n_params; i++) begin
      if (i == cut) begin
        send_op(srp_pkg::OP_TIMEOUT, 8'($urandom));
        return;
      end
      b = (i == 0) ? err : 8'($urandom);
      sum = sum + b;
      send_op(srp_pkg::OP_BYTE, b);
      if ($urandom_range(0, 19) == 0) send_op(OP_RESERVED, 8'($urandom));
    end
    if (cut == n_params + 1) begin
      send_op(srp_pkg::OP_TIMEOUT, 8'($urandom));
      return;
    end
    b = ~sum;
    if (shape == SHAPE_BAD_SUM) b = b ^ 8'($urandom_range(1, 255));
    send_op(srp_pkg::OP_BYTE, b);
  endtask

  task automatic random_replies(input int unsigned target);
    reply_shape_t shape;
    int unsigned  r;
    int unsigned  n;
    while (items_taken < target) begin
      r = $urandom_range(0, 99);
      if (r < 68)      shape = SHAPE_GOOD;
      else if (r < 76) shape = SHAPE_BAD_SUM;
      else if (r < 80) shape = SHAPE_SHORT;
      else if (r < 84) shape = SHAPE_LONG;
      else if (r < 90) shape = SHAPE_TIMEOUT;
      else if (r < 94) shape = SHAPE_NO_HEADER;
      else             shape = SHAPE_RESTART;
      r = $urandom_range(0, 9);
      if (r < 7)       n = $urandom_range(0, 4);
      else if (r < 9)  n = $urandom_range(5, srp_pkg::STORE_DEPTH);
      else             n = srp_pkg::STORE_DEPTH;
      send_reply(shape, n);
      if ($urandom_range(0, 9) == 0)
        send_op(2'($urandom_range(srp_pkg::OP_BYTE, OP_RESERVED)), 8'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [srp_pkg::IDX_W-1:0] settings [5];
    settings = '{5'd0, 5'd31, 5'd1, 5'($urandom_range(2, 29)), 5'd30};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    write_max_params(srp_pkg::MAX_PARAMS_RST);

    // ignored while idle, then a restart mid-hunt and a reserved code mid-body
    send_op(srp_pkg::OP_BYTE, 8'h00);
    send_op(srp_pkg::OP_TIMEOUT, 8'hFF);
    send_op(OP_RESERVED, 8'hA5);
    send_op(srp_pkg::OP_START, 8'h00);
    send_op(srp_pkg::OP_BYTE, srp_pkg::SYNC_BYTE);
    send_op(srp_pkg::OP_START, 8'hFF);
    send_op(srp_pkg::OP_BYTE, srp_pkg::SYNC_BYTE);
    send_op(srp_pkg::OP_BYTE, srp_pkg::SYNC_BYTE);
    send_op(srp_pkg::OP_BYTE, 8'hFE);
    send_op(srp_pkg::OP_BYTE, 8'h03);
    send_op(OP_RESERVED, 8'h5A);
    send_op(srp_pkg::OP_BYTE, 8'hFF);
    send_op(srp_pkg::OP_BYTE, 8'h00);
    send_op(srp_pkg::OP_BYTE, 8'hFF);
    // length too short, timeout, length too long
    send_op(srp_pkg::OP_START, 8'h00);
    send_op(srp_pkg::OP_BYTE, srp_pkg::SYNC_BYTE);
    send_op(srp_pkg::OP_BYTE, srp_pkg::SYNC_BYTE);
    send_op(srp_pkg::OP_BYTE, 8'h00);
    send_op(srp_pkg::OP_BYTE, 8'h01);
    send_op(srp_pkg::OP_START, 8'h00);
    send_op(srp_pkg::OP_TIMEOUT, 8'h00);
    send_op(srp_pkg::OP_START, 8'h00);
    send_op(srp_pkg::OP_BYTE, srp_pkg::SYNC_BYTE);
    send_op(srp_pkg::OP_BYTE, srp_pkg::SYNC_BYTE);
    send_op(srp_pkg::OP_BYTE, 8'h7F);
    send_op(srp_pkg::OP_BYTE, 8'hFF);

    foreach (settings[p]) begin
      settle();
      write_max_params(settings[p]);
      no_idle = (p == 2);
      if (p == 1) hold_off = 1'b1;
      random_replies(items_taken + PHASE_ITEMS);
    end
    no_idle = 1'b0;
    settle();
    if (tracker.pending() != 0)
      $display("%0t: %0d results never arrived", $time, tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/srp_pkg.sv
sv/srp_ctrl.sv
sv/srp_datapath.sv
sv/servo_reply_packet_parser_core.sv
sv/srp_checker.sv
bench/tb_top.sv
